// ----- design/nmgc_pkg.sv -----
// Shared widths, register codes and reset values for the normalized mixer gain control.
// No dependencies; imported by normalized_mixer_gain_control_core.
`default_nettype none
package nmgc_pkg;

   localparam int VOL_W   = 7;    // channel volume and control number width
   localparam int SUM_W   = 9;    // sum of four volumes
   localparam int GAIN_W  = 17;   // unsigned Q1.16 gain
   localparam int QBITS   = 17;   // quotient bits produced per channel
   localparam int CNT_W   = 5;    // holds QBITS - 1
   localparam int NUM_CH  = 4;
   localparam int CH_W    = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int REQ_DW  = 48;
   localparam int RSP_DW  = 24;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_OSC1  = 2'd0;
   localparam logic [1:0] REG_OSC2  = 2'd1;
   localparam logic [1:0] REG_OSC3  = 2'd2;
   localparam logic [1:0] REG_NOISE = 2'd3;

   // operation codes
   localparam logic OP_CONTROL = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   localparam logic [VOL_W-1:0] RST_OSC1_CN   = 7'd20;
   localparam logic [VOL_W-1:0] RST_OSC2_CN   = 7'd21;
   localparam logic [VOL_W-1:0] RST_OSC3_CN   = 7'd22;
   localparam logic [VOL_W-1:0] RST_NOISE_CN  = 7'd23;
   localparam logic [VOL_W-1:0] DEFAULT_VOLUME = 7'd42;

   typedef logic [VOL_W-1:0] vol_type;

endpackage
`default_nettype wire

// ----- design/normalized_mixer_gain_control_core.sv -----
// Normalized mixer gain control: four channel volumes, a serial divider for the gains,
// an APB-style register port. Depends on nmgc_pkg.
//
// Usage:
//   req channel: tuser = operation (0 control change, 1 load all four volumes);
//   tdata carries the control event fields and the four load volumes. A control
//   change writes every channel whose control number matches; a load writes all four.
//   rsp channel: after any change, four items in channel order, tuser = channel,
//   tdata = gain (volume * 65536 / volume sum, Q1.16, truncated, 0 for a zero sum),
//   tlast on the noise channel's item. An event that matches nothing gives no item.
//   Sequence: the item is taken, the volume sum is formed, then for each channel a
//   restoring divider produces the quotient bits (one quotient bit per cycle) and
//   the output register is loaded. An unmatched event leaves the block idle.
//   The block takes one item at a time; req_tready is high only while it is idle.
//   A stalled receiver holds the output register and the divider waits before
//   loading the next gain; the next item may be taken while the last gain waits.
//   Reset clears the volumes to 42, 42, 42, 0 and the control numbers to 20..23.
//   Registers (4-byte spacing): osc1, osc2, osc3, noise control numbers. Write them
//   only while the block is idle.
`default_nettype none
module normalized_mixer_gain_control_core
   import nmgc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   // request stream
   input  wire                req_tvalid,
   output logic               req_tready,
   // tdata: control_number[6:0], control_value[13:7], load_osc1_volume[20:14],
   //        load_osc2_volume[27:21], load_osc3_volume[34:28], load_noise_volume[41:35]
   input  wire [REQ_DW-1:0]   req_tdata,
   // tuser: operation[0]
   input  wire                req_tuser,
   // response stream
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   // tdata: channel_gain[16:0]
   output logic [RSP_DW-1:0]  rsp_tdata,
   // tuser: channel[1:0]
   output logic [CH_W-1:0]    rsp_tuser,
   output logic               rsp_tlast,
   // register port
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire [ADDR_W-1:0]   csr_paddr,
   input  wire [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   vol_type           cn_ff [NUM_CH];
   vol_type           vol_ff [NUM_CH];
   vol_type           vol_in [NUM_CH];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [GAIN_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic              out_valid_ff, out_valid_in;
   logic [GAIN_W-1:0] out_gain_ff, out_gain_in;
   logic [CH_W-1:0]   out_ch_ff, out_ch_in;
   logic              out_last_ff, out_last_in;

   logic              csr_write;
   logic              req_take;
   logic              hit;
   logic [SUM_W:0]    trial;
   logic              trial_ge;
   vol_type           ctl_num, ctl_val;
   vol_type           ld_vol [NUM_CH];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_OSC1:  csr_prdata = {{(DATA_W-VOL_W){1'b0}}, cn_ff[0]};
         REG_OSC2:  csr_prdata = {{(DATA_W-VOL_W){1'b0}}, cn_ff[1]};
         REG_OSC3:  csr_prdata = {{(DATA_W-VOL_W){1'b0}}, cn_ff[2]};
         REG_NOISE: csr_prdata = {{(DATA_W-VOL_W){1'b0}}, cn_ff[3]};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cn_ff[0] <= RST_OSC1_CN;
         cn_ff[1] <= RST_OSC2_CN;
         cn_ff[2] <= RST_OSC3_CN;
         cn_ff[3] <= RST_NOISE_CN;
      end else if (csr_write) begin
         cn_ff[csr_paddr[3:2]] <= csr_pwdata[VOL_W-1:0];
      end
   end

   assign ctl_num   = req_tdata[6:0];
   assign ctl_val   = req_tdata[13:7];
   assign ld_vol[0] = req_tdata[20:14];
   assign ld_vol[1] = req_tdata[27:21];
   assign ld_vol[2] = req_tdata[34:28];
   assign ld_vol[3] = req_tdata[41:35];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;

   // one divider step: the first compares the volume itself, later ones the doubled remainder
   assign trial    = (cnt_ff == CNT_W'(QBITS-1)) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign trial_ge = (trial >= {1'b0, sum_ff});

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      out_valid_in = out_valid_ff;
      out_gain_in  = out_gain_ff;
      out_ch_in    = out_ch_ff;
      out_last_in  = out_last_ff;
      hit          = 1'b0;
      for (int i = 0; i < NUM_CH; i++) vol_in[i] = vol_ff[i];

      if (rsp_tready) out_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser == OP_LOAD) begin
                  for (int i = 0; i < NUM_CH; i++) vol_in[i] = ld_vol[i];
                  state_in = ST_SUM;
               end else begin
                  for (int i = 0; i < NUM_CH; i++) begin
                     if (ctl_num == cn_ff[i]) begin
                        vol_in[i] = ctl_val;
                        hit       = 1'b1;
                     end
                  end
                  if (hit) state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            sum_in   = SUM_W'(vol_ff[0]) + SUM_W'(vol_ff[1])
                     + SUM_W'(vol_ff[2]) + SUM_W'(vol_ff[3]);
            ch_in    = '0;
            rem_in   = SUM_W'(vol_ff[0]);
            cnt_in   = CNT_W'(QBITS-1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[GAIN_W-2:0], trial_ge};
            rem_in = trial_ge ? SUM_W'(trial - {1'b0, sum_ff}) : trial[SUM_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_gain_in  = (sum_ff == '0) ? '0 : quo_ff;
               out_ch_in    = ch_ff;
               out_last_in  = (ch_ff == CH_W'(NUM_CH-1));
               if (ch_ff == CH_W'(NUM_CH-1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  rem_in   = SUM_W'(vol_ff[ch_ff + 1'b1]);
                  cnt_in   = CNT_W'(QBITS-1);
                  state_in = ST_DIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         vol_ff[0]    <= DEFAULT_VOLUME;
         vol_ff[1]    <= DEFAULT_VOLUME;
         vol_ff[2]    <= DEFAULT_VOLUME;
         vol_ff[3]    <= '0;
         ch_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < NUM_CH; i++) vol_ff[i] <= vol_in[i];
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      out_gain_ff <= out_gain_in;
      out_ch_ff   <= out_ch_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-GAIN_W){1'b0}}, out_gain_ff};
   assign rsp_tuser  = out_ch_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for normalized_mixer_gain_control_core: directed table, then random
// events under several idling mixes, with gains predicted from a local volume model
// or, for some directed rows, written out by hand. Depends on nmgc_pkg and the core RTL.
`timescale 1ns / 100ps
module testbench
   import nmgc_pkg::*;
();

   typedef struct packed {
      logic         op;
      vol_type      num;
      vol_type      val;
      logic [27:0]  loads;   // {noise, osc3, osc2, osc1}
      logic [1:0]   cfg;     // control number set in force
      logic         typed;   // gains below are written out by hand
      logic [67:0]  gains;   // {noise, osc3, osc2, osc1}
   } event_row_type;

   typedef struct {
      logic [CH_W-1:0]   chan;
      logic [GAIN_W-1:0] gain;
      logic              is_last;
   } gain_item_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [CH_W-1:0]     rsp_tuser;
   logic                rsp_tlast;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   vol_type        chan_volume [NUM_CH];
   vol_type        ctl_number [NUM_CH];
   gain_item_type  pending_gains [$];
   int             mismatches = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;

   // {noise, osc3, osc2, osc1}
   logic [27:0] ctl_sets [0:3] = '{
      {7'd23, 7'd22, 7'd21, 7'd20},
      {7'd0, 7'd0, 7'd0, 7'd0},
      {7'd1, 7'd0, 7'd127, 7'd127},
      {7'd126, 7'd77, 7'd9, 7'd5}
   };

   event_row_type event_rows [0:22] = '{
      '{OP_CONTROL, 7'd23, 7'd0, 28'd0, 2'd0, 1'b1, {17'd0, 17'd21845, 17'd21845, 17'd21845}},
      '{OP_CONTROL, 7'd5, 7'd99, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_LOAD, 7'd0, 7'd0, 28'd0, 2'd0, 1'b1, 68'd0},
      '{OP_CONTROL, 7'd20, 7'd127, 28'd0, 2'd0, 1'b1, {17'd0, 17'd0, 17'd0, 17'd65536}},
      '{OP_LOAD, 7'd127, 7'd127, {7'd127, 7'd127, 7'd127, 7'd127}, 2'd0, 1'b1,
        {17'd16384, 17'd16384, 17'd16384, 17'd16384}},
      '{OP_LOAD, 7'd0, 7'd0, {7'd1, 7'd0, 7'd0, 7'd0}, 2'd0, 1'b1,
        {17'd65536, 17'd0, 17'd0, 17'd0}},
      '{OP_LOAD, 7'd0, 7'd0, {7'd127, 7'd127, 7'd127, 7'd1}, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd21, 7'd0, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd22, 7'd0, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd23, 7'd0, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd127, 7'd127, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd0, 7'd0, 28'd0, 2'd0, 1'b0, 68'd0},
      '{OP_LOAD, 7'd20, 7'd5, {7'd11, 7'd7, 7'd5, 7'd3}, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd22, 7'd64, {7'd127, 7'd127, 7'd127, 7'd127}, 2'd0, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd0, 7'd127, 28'd0, 2'd1, 1'b1,
        {17'd16384, 17'd16384, 17'd16384, 17'd16384}},
      '{OP_CONTROL, 7'd0, 7'd0, 28'd0, 2'd1, 1'b1, 68'd0},
      '{OP_CONTROL, 7'd20, 7'd50, 28'd0, 2'd1, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd127, 7'd100, 28'd0, 2'd2, 1'b1, {17'd0, 17'd0, 17'd32768, 17'd32768}},
      '{OP_CONTROL, 7'd1, 7'd127, 28'd0, 2'd2, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd0, 7'd1, 28'd0, 2'd2, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd126, 7'd127, 28'd0, 2'd3, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd77, 7'd3, 28'd0, 2'd3, 1'b0, 68'd0},
      '{OP_CONTROL, 7'd20, 7'd9, 28'd0, 2'd3, 1'b0, 68'd0}
   };

   normalized_mixer_gain_control_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Update the volumes for one event; report whether a set of gains follows.
   function automatic bit apply_event(input logic op, input logic [REQ_DW-1:0] data);
      bit hit;
      hit = 1'b0;
      if (op == OP_LOAD) begin
         for (int ch = 0; ch < NUM_CH; ch++)
            chan_volume[ch] = data[14 + 7*ch +: 7];
         hit = 1'b1;
      end else begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            if (data[6:0] == ctl_number[ch]) begin
               chan_volume[ch] = data[13:7];
               hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   function automatic void queue_gains();
      int unsigned total;
      int unsigned g;
      total = 0;
      for (int ch = 0; ch < NUM_CH; ch++)
         total += chan_volume[ch];
      for (int ch = 0; ch < NUM_CH; ch++) begin
         g = (total == 0) ? 0 : (chan_volume[ch] * 32'd65536) / total;
         pending_gains.push_back('{chan: ch[CH_W-1:0], gain: g[GAIN_W-1:0],
                                   is_last: (ch == NUM_CH - 1)});
      end
   endfunction

   function automatic vol_type pick_volume();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 7'd0;
      if (r == 1) return 7'd127;
      return vol_type'($urandom_range(127));
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_event(input logic op, input logic [REQ_DW-1:0] data,
                             input logic typed, input logic [67:0] gains, output bit hit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DW'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      hit = apply_event(op, data);
      if (hit) begin
         if (typed) begin
            for (int ch = 0; ch < NUM_CH; ch++)
               pending_gains.push_back('{chan: ch[CH_W-1:0], gain: gains[17*ch +: 17],
                                         is_last: (ch == NUM_CH - 1)});
         end else begin
            queue_gains();
         end
      end
      @(negedge clock);
   endtask

   // Hold the sender until every gain has come out and the divider has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_gains.size() != 0);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input vol_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(DATA_W - VOL_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ctl_number[idx] = value;
      @(negedge clock);
   endtask

   task automatic load_ctl_set(input logic [27:0] set);
      wait_idle();
      csr_write(REG_OSC1, set[6:0]);
      csr_write(REG_OSC2, set[13:7]);
      csr_write(REG_OSC3, set[20:14]);
      csr_write(REG_NOISE, set[27:21]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      gain_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_gains.size() == 0) begin
            $error("unexpected gain item: channel %0d gain %0d", rsp_tuser,
                   rsp_tdata[GAIN_W-1:0]);
            mismatches++;
         end else begin
            want = pending_gains.pop_front();
            if (rsp_tuser !== want.chan) begin
               $error("channel: expected %0d, actual %0d", want.chan, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[GAIN_W-1:0] !== want.gain) begin
               $error("channel_gain: expected %0d, actual %0d", want.gain,
                      rsp_tdata[GAIN_W-1:0]);
               mismatches++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last_gain: expected %0d, actual %0d", want.is_last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [1:0]        active_set;
      logic              op;
      vol_type           num;
      logic [REQ_DW-1:0] data;
      logic [27:0]       set;
      bit                hit;
      int                sets_out;
      int                idle_mix [4];
      int                stall_mix [4];

      idle_mix    = '{0, 46, 0, 17};
      stall_mix   = '{0, 0, 46, 17};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      chan_volume = '{DEFAULT_VOLUME, DEFAULT_VOLUME, DEFAULT_VOLUME, 7'd0};
      ctl_number  = '{RST_OSC1_CN, RST_OSC2_CN, RST_OSC3_CN, RST_NOISE_CN};
      active_set  = 2'd0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (event_rows[i]) begin
         if (event_rows[i].cfg != active_set) begin
            load_ctl_set(ctl_sets[event_rows[i].cfg]);
            active_set = event_rows[i].cfg;
         end
         send_event(event_rows[i].op,
                    {6'b0, event_rows[i].loads, event_rows[i].val, event_rows[i].num},
                    event_rows[i].typed, event_rows[i].gains, hit);
      end

      for (int phase = 0; phase < 4; phase++) begin
         set[6:0]   = vol_type'($urandom_range(127));
         set[13:7]  = ($urandom_range(3) == 0) ? set[6:0] : vol_type'($urandom_range(127));
         set[20:14] = vol_type'($urandom_range(127));
         set[27:21] = ($urandom_range(3) == 0) ? set[20:14] : vol_type'($urandom_range(127));
         load_ctl_set(set);
         sender_idle_pct    = idle_mix[phase];
         receiver_stall_pct = stall_mix[phase];
         sets_out = 0;
         while (sets_out < 30) begin
            if ($urandom_range(49) == 0)
               wait_idle();
            op  = ($urandom_range(9) < 3) ? OP_LOAD : OP_CONTROL;
            num = ($urandom_range(3) != 0) ? ctl_number[$urandom_range(NUM_CH - 1)]
                                           : vol_type'($urandom_range(127));
            data = {6'b0, pick_volume(), pick_volume(), pick_volume(), pick_volume(),
                    pick_volume(), num};
            send_event(op, data, 1'b0, 68'd0, hit);
            if (hit)
               sets_out++;
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_gains.size() != 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_gains.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
